// ===== rtl/core/tts_pkg.sv =====
// Shared types and constants of the timed task slot scheduler.
// No dependencies; every other file of the block but tts_ram imports this package.
`timescale 1ns / 1ps
package tts_pkg;

    localparam int NUM_SLOTS     = 64;
    localparam int SLOT_W        = $clog2(NUM_SLOTS);
    localparam int HANDLER_BITS  = 16;
    localparam int TIME_BITS     = 32;
    localparam int STATUS_BITS   = 32;
    localparam int OPCODE_BITS   = 4;
    localparam int INDEX_BITS    = 6;

    localparam logic [OPCODE_BITS-1:0] OP_IMM        = 4'd0;
    localparam logic [OPCODE_BITS-1:0] OP_DEL        = 4'd1;
    localparam logic [OPCODE_BITS-1:0] OP_PER        = 4'd2;
    localparam logic [OPCODE_BITS-1:0] OP_IMM_UNIQUE = 4'd3;
    localparam logic [OPCODE_BITS-1:0] OP_DEL_UNIQUE = 4'd4;
    localparam logic [OPCODE_BITS-1:0] OP_SET_STATUS = 4'd5;
    localparam logic [OPCODE_BITS-1:0] OP_ABORT      = 4'd6;
    localparam logic [OPCODE_BITS-1:0] OP_TICK       = 4'd7;
    localparam logic [OPCODE_BITS-1:0] OP_INIT       = 4'd8;

    typedef enum logic [1:0] {
        KIND_FREE,
        KIND_IMM,
        KIND_DEL,
        KIND_PER
    } t_slot_kind;

    typedef enum logic [1:0] {
        RES_REPLY,
        RES_FIRED,
        RES_EMPTY,
        RES_ACK
    } t_res_kind;

    typedef struct packed {
        t_slot_kind              kind;
        logic [HANDLER_BITS-1:0] handler;
        logic [TIME_BITS-1:0]    limit;
        logic [TIME_BITS-1:0]    elapsed;
        logic [STATUS_BITS-1:0]  status;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    typedef struct packed {
        logic [OPCODE_BITS-1:0]     opcode;
        logic [HANDLER_BITS-1:0]    handler_id;
        logic [TIME_BITS-1:0]       time_value;
        logic signed [STATUS_BITS-1:0] status_value;
        logic [INDEX_BITS-1:0]      slot_index;
        logic [TIME_BITS-1:0]       now_time;
    } t_in_item;

    typedef struct packed {
        t_res_kind                  kind;
        logic                       accepted;
        logic [INDEX_BITS-1:0]      out_slot;
        logic [HANDLER_BITS-1:0]    fired_handler;
        logic signed [STATUS_BITS-1:0] fired_status;
        logic                       last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_EVAL,
        ST_REPLY,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load_req;
        logic ram_write;
        logic found_set;
        logic idx_inc;
        logic tick_step;
        logic load_reply;
        logic load_flush;
    } t_cmd;

    typedef struct packed {
        logic op_sched;
        logic op_unique;
        logic op_tick;
        logic op_status_ok;
        logic idx_last;
        logic hit_match;
        logic hit_free;
        logic found_valid;
        logic fire;
        logic hold_valid;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/tts_in_if.sv =====
// Request channel of the scheduler: valid, ready and one request item.
// Depends on tts_pkg.
`timescale 1ns / 1ps
interface tts_in_if;
    import tts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tts_out_if.sv =====
// Result channel of the scheduler: valid, ready and one result item.
// Depends on tts_pkg.
`timescale 1ns / 1ps
interface tts_out_if;
    import tts_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/tts_ctrl.sv =====
// Sequencer of the scheduler: walks the slot table for scans and ticks.
// Depends on tts_pkg; drives the datapath in tts_dpath.
`timescale 1ns / 1ps
module tts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tts_pkg::t_stat i_stat,
    output tts_pkg::t_cmd  o_cmd
);
    import tts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.op_sched || i_stat.op_tick || i_stat.op_status_ok) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_REPLY;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.op_tick) begin
                    // A second firing task can only be taken once the held one moves out.
                    if (!(i_stat.fire && i_stat.hold_valid && !i_stat.out_free)) begin
                        o_cmd.ram_write = 1'b1;
                        o_cmd.tick_step = 1'b1;
                        if (i_stat.idx_last) begin
                            n_state = ST_FLUSH;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = ST_READ;
                        end
                    end
                end else if (i_stat.op_sched) begin
                    if (i_stat.hit_match || (i_stat.hit_free && !i_stat.found_valid)) begin
                        o_cmd.found_set = 1'b1;
                    end
                    if (i_stat.hit_match || (i_stat.hit_free && !i_stat.op_unique)
                            || i_stat.idx_last) begin
                        n_state = ST_REPLY;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end else begin
                    o_cmd.ram_write = 1'b1;
                    n_state         = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.load_reply = 1'b1;
                    o_cmd.ram_write  = i_stat.op_sched && i_stat.found_valid;
                    n_state          = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_flush = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/tts_dpath.sv =====
// Datapath of the scheduler: slot table, valid bits, tick arithmetic,
// hold and output registers. Depends on tts_pkg and tts_ram.
`timescale 1ns / 1ps
module tts_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tts_pkg::t_in_item i_req,
    input  tts_pkg::t_cmd     i_cmd,
    output tts_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tts_pkg::t_out_item o_out
);
    import tts_pkg::*;

    t_in_item               r_req;
    logic [TIME_BITS-1:0]   r_prev;
    logic [TIME_BITS-1:0]   r_delta;
    logic [NUM_SLOTS-1:0]   r_valid;
    logic                   r_rd_vld;
    logic [SLOT_W-1:0]      r_idx;
    logic [SLOT_W-1:0]      r_found;
    logic                   r_found_v;
    t_out_item              r_hold;
    logic                   r_hold_v;
    t_out_item              r_out;
    logic                   r_out_v;

    logic [ENTRY_W-1:0]     w_rdata;
    t_slot_entry            rd;
    t_slot_entry            upd;
    t_slot_entry            wentry;
    t_slot_entry            sched_entry;
    logic [SLOT_W-1:0]      waddr;
    logic [TIME_BITS:0]     sum;
    logic [TIME_BITS-1:0]   new_el;
    logic                   active;
    logic                   fire;
    logic                   op_sched;
    logic                   op_unique;
    logic                   op_tick;
    logic                   op_status;
    logic                   idx_ok;
    logic                   in_idx_ok;
    logic                   out_free;
    logic                   out_load;
    t_out_item              out_next;
    t_out_item              cur_fire;

    assign op_sched  = r_req.opcode <= OP_DEL_UNIQUE;
    assign op_unique = (r_req.opcode == OP_IMM_UNIQUE) || (r_req.opcode == OP_DEL_UNIQUE);
    assign op_tick   = r_req.opcode == OP_TICK;
    assign op_status = r_req.opcode == OP_SET_STATUS;
    assign idx_ok    = 32'(r_req.slot_index) < 32'(NUM_SLOTS);
    assign in_idx_ok = 32'(i_req.slot_index) < 32'(NUM_SLOTS);
    assign out_free  = !r_out_v || i_out_ready;

    // An entry that was never written since reset, init or abort reads as a free, zero slot.
    assign rd = r_rd_vld ? t_slot_entry'(w_rdata) : '0;

    always_comb begin
        sum    = {1'b0, rd.elapsed} + {1'b0, r_delta};
        new_el = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        active = (rd.kind != KIND_FREE) && (rd.handler != '0);
        fire   = active && ((rd.kind == KIND_IMM) || (new_el >= rd.limit));
        upd    = rd;
        if (active) begin
            upd.elapsed = new_el;
            if (fire) begin
                if (rd.kind == KIND_PER) begin
                    upd.elapsed = '0;
                end else begin
                    upd.kind = KIND_FREE;
                end
            end
        end
    end

    always_comb begin
        sched_entry.handler = r_req.handler_id;
        sched_entry.elapsed = '0;
        sched_entry.status  = (r_req.opcode == OP_IMM_UNIQUE) ? '0 : r_req.status_value;
        case (r_req.opcode)
            OP_IMM, OP_IMM_UNIQUE: sched_entry.kind = KIND_IMM;
            OP_PER:                sched_entry.kind = KIND_PER;
            default:               sched_entry.kind = KIND_DEL;
        endcase
        sched_entry.limit = (sched_entry.kind == KIND_IMM) ? '0 : r_req.time_value;
    end

    always_comb begin
        wentry = rd;
        waddr  = r_idx;
        if (op_tick) begin
            wentry = upd;
        end else if (op_status) begin
            wentry.status = r_req.status_value;
        end else begin
            wentry = sched_entry;
            waddr  = r_found;
        end
    end

    always_comb begin
        cur_fire               = '0;
        cur_fire.kind          = RES_FIRED;
        cur_fire.out_slot      = INDEX_BITS'(r_idx);
        cur_fire.fired_handler = rd.handler;
        cur_fire.fired_status  = rd.status;

        out_load = 1'b0;
        out_next = r_hold;
        if (i_cmd.load_reply) begin
            out_load      = 1'b1;
            out_next      = '0;
            out_next.last = 1'b1;
            if (op_sched) begin
                out_next.kind     = RES_REPLY;
                out_next.accepted = r_found_v;
                out_next.out_slot = r_found_v ? INDEX_BITS'(r_found) : '0;
            end else begin
                out_next.kind = RES_ACK;
            end
        end else if (i_cmd.load_flush) begin
            out_load      = 1'b1;
            out_next.last = 1'b1;
            if (!r_hold_v) begin
                out_next      = '0;
                out_next.kind = RES_EMPTY;
                out_next.last = 1'b1;
            end
        end else if (i_cmd.tick_step && fire && r_hold_v) begin
            out_load = 1'b1;
        end
    end

    tts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_write),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_idx     <= '0;
            r_found_v <= 1'b0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[r_idx];
            if (i_cmd.load_req) begin
                r_req     <= i_req;
                r_found_v <= 1'b0;
                r_hold_v  <= 1'b0;
                r_idx     <= (i_req.opcode == OP_SET_STATUS) ? SLOT_W'(i_req.slot_index) : '0;
                r_delta   <= (r_prev > i_req.now_time) ? i_req.now_time
                                                       : i_req.now_time - r_prev;
                if (i_req.opcode == OP_TICK || i_req.opcode == OP_INIT) begin
                    r_prev <= i_req.now_time;
                end
                if (i_req.opcode == OP_INIT) begin
                    r_valid <= '0;
                end else if (i_req.opcode == OP_ABORT && in_idx_ok) begin
                    r_valid[SLOT_W'(i_req.slot_index)] <= 1'b0;
                end
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (i_cmd.ram_write) begin
                r_valid[waddr] <= 1'b1;
            end
            if (i_cmd.found_set) begin
                r_found   <= r_idx;
                r_found_v <= 1'b1;
            end
            if (i_cmd.tick_step && fire) begin
                r_hold   <= cur_fire;
                r_hold_v <= 1'b1;
            end else if (i_cmd.load_flush) begin
                r_hold_v <= 1'b0;
            end
            if (out_load) begin
                r_out   <= out_next;
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat              = '0;
        o_stat.op_sched     = op_sched;
        o_stat.op_unique    = op_unique;
        o_stat.op_tick      = op_tick;
        o_stat.op_status_ok = op_status && idx_ok;
        o_stat.idx_last     = r_idx == SLOT_W'(NUM_SLOTS - 1);
        o_stat.hit_match    = op_unique && (rd.kind != KIND_FREE)
                              && (rd.handler == r_req.handler_id);
        o_stat.hit_free     = rd.kind == KIND_FREE;
        o_stat.found_valid  = r_found_v;
        o_stat.fire         = fire;
        o_stat.hold_valid   = r_hold_v;
        o_stat.out_free     = out_free;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
endmodule

// ===== rtl/core/timed_task_slot_scheduler_core.sv =====
// Timed task slot scheduler, top level. Schedule requests scan the table slot by slot, each
// slot visited in a read and an evaluate state; a tick visits every slot the same way, as
// the slot table has a single read port. Set status reads and rewrites its one slot before
// the reply; the other requests go straight to the reply. A new request is taken while the
// last result still waits. Reset empties the table at once through per-slot valid bits and
// zeroes the stored time. Depends on tts_pkg, tts_in_if, tts_out_if, tts_ram, tts_ctrl
// and tts_dpath.
`timescale 1ns / 1ps
module timed_task_slot_scheduler_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tts_in_if.sink    i_in,
    tts_out_if.source o_res
);
    import tts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tts_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out       (o_res.data)
    );
endmodule

// ===== sim/tb_timed_task_slot_scheduler_core.sv =====
// Self-checking bench for the timed task slot scheduler core.
// Depends on tts_pkg, tts_in_if, tts_out_if and the core; an internal slot-table predictor
// computes the expected results of every request transfer.
`timescale 1ns / 1ps
module tb_timed_task_slot_scheduler_core;
    import tts_pkg::*;

    class sched_scoreboard;
        t_slot_kind             kind_q[NUM_SLOTS];
        logic [HANDLER_BITS-1:0] hnd_q[NUM_SLOTS];
        logic [TIME_BITS-1:0]   lim_q[NUM_SLOTS];
        logic [TIME_BITS-1:0]   ela_q[NUM_SLOTS];
        logic [STATUS_BITS-1:0] sts_q[NUM_SLOTS];
        logic [TIME_BITS-1:0]   prev_now;
        t_out_item              pending_results[$];
        int                     errors;
        int                     fired_seen;
        int                     replies_seen;

        function new();
            errors = 0;
            fired_seen = 0;
            replies_seen = 0;
            prev_now = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                clear(i);
            end
        endfunction

        function void clear(int i);
            kind_q[i] = KIND_FREE;
            hnd_q[i] = '0;
            lim_q[i] = '0;
            ela_q[i] = '0;
            sts_q[i] = '0;
        endfunction

        function void push(t_res_kind k, logic acc, int slot, logic [HANDLER_BITS-1:0] h,
                           logic [STATUS_BITS-1:0] s);
            t_out_item r;
            r.kind = k;
            r.accepted = acc;
            r.out_slot = slot[INDEX_BITS-1:0];
            r.fired_handler = h;
            r.fired_status = s;
            r.last = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void note_request(t_in_item it);
            int found;
            int n;
            bit uniq;
            bit fire;
            t_slot_kind nk;
            logic [TIME_BITS-1:0] delta;
            n = 0;
            found = -1;
            if (it.opcode <= OP_DEL_UNIQUE) begin
                uniq = (it.opcode >= OP_IMM_UNIQUE);
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (uniq && kind_q[i] != KIND_FREE && hnd_q[i] == it.handler_id) begin
                        found = i;
                        break;
                    end
                    if (found < 0 && kind_q[i] == KIND_FREE) begin
                        found = i;
                        if (!uniq) break;
                    end
                end
                if (found >= 0) begin
                    case (it.opcode)
                        OP_DEL, OP_DEL_UNIQUE: nk = KIND_DEL;
                        OP_PER: nk = KIND_PER;
                        default: nk = KIND_IMM;
                    endcase
                    kind_q[found] = nk;
                    hnd_q[found] = it.handler_id;
                    lim_q[found] = (nk == KIND_IMM) ? '0 : it.time_value;
                    ela_q[found] = '0;
                    sts_q[found] = (it.opcode == OP_IMM_UNIQUE) ? '0 : it.status_value;
                    push(RES_REPLY, 1'b1, found, '0, '0);
                end else begin
                    push(RES_REPLY, 1'b0, 0, '0, '0);
                end
                n = 1;
            end else if (it.opcode == OP_TICK) begin
                delta = (prev_now > it.now_time) ? it.now_time : it.now_time - prev_now;
                prev_now = it.now_time;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (kind_q[i] == KIND_FREE || hnd_q[i] == '0) continue;
                    if (delta > ~ela_q[i]) ela_q[i] = '1;
                    else ela_q[i] = ela_q[i] + delta;
                    fire = 1'b0;
                    if (kind_q[i] == KIND_IMM) begin
                        fire = 1'b1;
                        kind_q[i] = KIND_FREE;
                    end else if (ela_q[i] >= lim_q[i]) begin
                        fire = 1'b1;
                        if (kind_q[i] == KIND_DEL) kind_q[i] = KIND_FREE;
                        else ela_q[i] = '0;
                    end
                    if (fire && n < NUM_SLOTS) begin
                        push(RES_FIRED, 1'b0, i, hnd_q[i], sts_q[i]);
                        n++;
                    end
                end
                if (n == 0) begin
                    push(RES_EMPTY, 1'b0, 0, '0, '0);
                    n = 1;
                end
            end else begin
                if (it.opcode == OP_SET_STATUS) sts_q[it.slot_index] = it.status_value;
                else if (it.opcode == OP_ABORT) clear(it.slot_index);
                else if (it.opcode == OP_INIT) begin
                    for (int i = 0; i < NUM_SLOTS; i++) clear(i);
                    prev_now = it.now_time;
                end
                push(RES_ACK, 1'b0, 0, '0, '0);
                n = 1;
            end
            pending_results[$].last = 1'b1;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind == RES_FIRED) fired_seen++;
            if (got.kind == RES_REPLY) replies_seen++;
            if (got.kind !== want.kind)
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            if (got.accepted !== want.accepted)
                $display("%0t: accepted expected %0d actual %0d", $time, want.accepted,
                         got.accepted);
            if (got.out_slot !== want.out_slot)
                $display("%0t: out_slot expected %0d actual %0d", $time, want.out_slot,
                         got.out_slot);
            if (got.fired_handler !== want.fired_handler)
                $display("%0t: fired_handler expected %0h actual %0h", $time,
                         want.fired_handler, got.fired_handler);
            if (got.fired_status !== want.fired_status)
                $display("%0t: fired_status expected %0h actual %0h", $time,
                         want.fired_status, got.fired_status);
            if (got.last !== want.last)
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got !== want) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tts_in_if  req_ch ();
    tts_out_if res_ch ();

    timed_task_slot_scheduler_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch.sink),
        .o_res  (res_ch.source)
    );

    sched_scoreboard board;
    int requests_sent;
    bit hold_off;
    logic [HANDLER_BITS-1:0] handler_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timed_task_slot_scheduler_core: mismatch");
        $finish;
    end

    // Receiver: random stall pattern, plus one long hold-off on request.
    initial begin
        int phase;
        res_ch.ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off) res_ch.ready <= 1'b0;
            else if (phase % 97 < 30) res_ch.ready <= 1'b1;
            else res_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
    end

    task automatic send(t_in_item it);
        req_ch.data <= it;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(it);
        requests_sent++;
    endtask

    task automatic go_idle(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (board.pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_in_item make(logic [OPCODE_BITS-1:0] op,
                                      logic [HANDLER_BITS-1:0] h,
                                      logic [TIME_BITS-1:0] tv, logic [STATUS_BITS-1:0] st,
                                      logic [INDEX_BITS-1:0] idx, logic [TIME_BITS-1:0] nw);
        t_in_item it;
        it.opcode = op;
        it.handler_id = h;
        it.time_value = tv;
        it.status_value = st;
        it.slot_index = idx;
        it.now_time = nw;
        return it;
    endfunction

    function automatic t_in_item random_request(logic [TIME_BITS-1:0] clock_now);
        int pick;
        logic [OPCODE_BITS-1:0] op;
        logic [TIME_BITS-1:0] tv;
        logic [HANDLER_BITS-1:0] h;
        pick = $urandom_range(0, 99);
        if (pick < 14) op = OP_IMM;
        else if (pick < 28) op = OP_DEL;
        else if (pick < 40) op = OP_PER;
        else if (pick < 47) op = OP_IMM_UNIQUE;
        else if (pick < 55) op = OP_DEL_UNIQUE;
        else if (pick < 61) op = OP_SET_STATUS;
        else if (pick < 67) op = OP_ABORT;
        else if (pick < 95) op = OP_TICK;
        else if (pick < 97) op = OP_INIT;
        else op = OPCODE_BITS'($urandom_range(9, 15));
        tv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 400);
        h = ($urandom_range(0, 4) == 0) ? HANDLER_BITS'($urandom)
                                        : handler_pool[$urandom_range(0, 7)];
        return make(op, h, tv, $urandom, INDEX_BITS'($urandom), clock_now);
    endfunction

    initial begin
        logic [TIME_BITS-1:0] clk_now;
        int burst;
        board = new();
        requests_sent = 0;
        hold_off = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        for (int i = 0; i < 8; i++) handler_pool[i] = (i == 0) ? '0 : HANDLER_BITS'($urandom);
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation, field extremes, zero handler, unique match,
        // free slots at the top index, unknown opcode, rollover and saturation.
        send(make(OP_INIT, '0, '0, '0, '0, 32'd1000));
        send(make(OP_IMM, 16'hFFFF, '1, 32'h8000_0000, '1, '1));
        send(make(OP_DEL, 16'h0001, 32'd50, 32'h7FFF_FFFF, '0, '0));
        send(make(OP_PER, 16'h1234, 32'd20, 32'hFFFF_FFFF, '0, '0));
        send(make(OP_DEL, '0, 32'd0, 32'h5, '0, '0));
        send(make(OP_IMM_UNIQUE, 16'h1234, 32'd7, 32'hDEAD, '0, '0));
        send(make(OP_DEL_UNIQUE, 16'hABCD, '1, 32'h1, '0, '0));
        send(make(OP_DEL_UNIQUE, 16'h0001, 32'd30, 32'h2, '0, '0));
        send(make(OP_SET_STATUS, '0, '0, 32'h1357_9BDF, 6'd1, '0));
        send(make(OP_SET_STATUS, '0, '0, 32'h1, 6'd63, '0));
        send(make(OP_TICK, '0, '0, '0, '0, 32'd1040));
        send(make(OP_PER, 16'h2222, 32'd0, 32'h3, '0, '0));
        send(make(OP_TICK, '0, '0, '0, '0, 32'd1040));
        send(make(OP_TICK, '0, '0, '0, '0, '1));
        send(make(OP_TICK, '0, '0, '0, '0, 32'd5));
        send(make(OP_ABORT, '0, '0, '0, 6'd2, '0));
        send(make(OP_ABORT, '0, '0, '0, 6'd63, '0));
        send(make(4'd9, '0, '0, '0, '0, '0));
        send(make(4'd15, '1, '1, '1, '1, '1));
        send(make(OP_TICK, '0, '0, '0, '0, '0));
        drain();

        // Fill the table, then overflow it, then fire all 64 at once.
        send(make(OP_INIT, '0, '0, '0, '0, '0));
        for (int i = 0; i < NUM_SLOTS + 2; i++)
            send(make(OP_IMM, HANDLER_BITS'(i + 1), '0, STATUS_BITS'(i), '0, '0));
        send(make(OP_TICK, '0, '0, '0, '0, 32'd1));
        drain();

        // Long receiver hold-off while requests keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send(make(OP_TICK, '0, '0, '0, '0, 32'd10 + i));
        join
        drain();

        clk_now = 32'd100;
        while (requests_sent < 230) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                clk_now = ($urandom_range(0, 40) == 0) ? $urandom_range(0, 50)
                          : clk_now + $urandom_range(0, 120);
                send(random_request(clk_now));
            end
            if ($urandom_range(0, 2) == 0) go_idle($urandom_range(1, 20));
            if ($urandom_range(0, 30) == 0) drain();
        end
        drain();

        $display("Sent %0d requests; %0d schedule replies and %0d fired tasks checked.",
                 requests_sent, board.replies_seen, board.fired_seen);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("timed_task_slot_scheduler_core: match");
        end else begin
            $display("timed_task_slot_scheduler_core: mismatch");
        end
        $finish;
    end
endmodule
